### hdl/palette_slot_refcount_allocator_assert.svh
// Assertion macros used by the palette slot allocator checker.
`ifndef PALETTE_SLOT_REFCOUNT_ALLOCATOR_ASSERT_SVH
`define PALETTE_SLOT_REFCOUNT_ALLOCATOR_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is held.
`define PSRA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("psra assertion failed");

// Implication checked in the following cycle, masked while reset is held.
`define PSRA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("psra assertion failed");

// Implication checked in the following cycle, active during reset as well.
`define PSRA_ASSERT_ALWAYS_NEXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("psra assertion failed");

`endif

### hdl/psra_pkg.sv
// Types and constants shared by the palette slot allocator modules.
package psra_pkg;

  // Index width wide enough for the largest supported table.
  localparam int IDX_W = 8;

  localparam logic [15:0] NO_SLOT  = 16'hffff;
  localparam logic [15:0] REFS_MAX = 16'hffff;

  typedef enum logic [2:0] {
    MODE_ACQUIRE,
    MODE_RELEASE,
    MODE_FIND,
    MODE_COPY,
    MODE_CLEAR
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOT_FOUND,
    STAT_NO_FREE,
    STAT_BAD_RELEASE
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // Search token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             drop_zero;
  } tok_t;

  // Command fields every cell compares against during the search.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] tick;
    logic [15:0] drop_slot;
  } scan_t;

  // Table update broadcast to all cells at once.
  typedef struct packed {
    logic             fire;
    logic             clr;
    logic             drop_en;
    logic [IDX_W-1:0] drop_idx;
    logic             add_en;
    logic [IDX_W-1:0] add_idx;
    logic             key_we;
    logic [31:0]      key;
    logic [31:0]      tick;
  } upd_t;

endpackage

### hdl/psra_cell.sv
// One palette slot: key, reference count, free stamp, and one search stage.
module psra_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  psra_pkg::scan_t scan,
  input  psra_pkg::upd_t  upd,
  input  psra_pkg::tok_t  tok_i,
  output psra_pkg::tok_t  tok_o
);
  import psra_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [31:0] key_r;
  logic [15:0] refs_r;
  logic [31:0] ftick_r;
  tok_t        tok_r, tok_nxt;
  logic        is_match, is_free;
  logic        drop_here;
  logic [15:0] refs_dec;

  // Compare this slot against the command.
  assign is_match = (key_r == scan.key);
  assign is_free  = (refs_r == 16'd0) && ((ftick_r == 32'd0) || (ftick_r != scan.tick));

  // Fold this slot into the passing token; lower slots already won if hit.
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      if (!tok_i.match_hit && is_match) begin
        tok_nxt.match_hit = 1'b1;
        tok_nxt.match_idx = MY_IDX;
      end
      if (!tok_i.free_hit && is_free) begin
        tok_nxt.free_hit = 1'b1;
        tok_nxt.free_idx = MY_IDX;
      end
      if (scan.drop_slot == 16'(IDX)) begin
        tok_nxt.drop_zero = (refs_r == 16'd0);
      end
    end
  end

  // Advance the token to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  // Drop first, then add, so a copy onto the same slot behaves in order.
  assign drop_here = upd.drop_en && (upd.drop_idx == MY_IDX);
  assign refs_dec  = drop_here ? (refs_r - 16'd1) : refs_r;

  // Apply the broadcast update to this slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      refs_r  <= '0;
      ftick_r <= '0;
    end else if (upd.fire) begin
      if (upd.clr) begin
        key_r   <= '0;
        refs_r  <= '0;
        ftick_r <= '0;
      end else begin
        if (drop_here && (refs_r == 16'd1)) begin
          ftick_r <= upd.tick;
        end
        if (upd.add_en && (upd.add_idx == MY_IDX) && (refs_dec != REFS_MAX)) begin
          refs_r <= refs_dec + 16'd1;
        end else begin
          refs_r <= refs_dec;
        end
        if (upd.key_we && (upd.add_idx == MY_IDX)) begin
          key_r <= upd.key;
        end
      end
    end
  end

endmodule

### hdl/palette_slot_refcount_allocator.sv
// Top level of the reference-counted palette slot allocator.
//
// Input channel (in_valid / in_stall): one command word per request, with
// in_mode selecting acquire, release, find, copy or clear.
// Output channel (out_valid / out_stall): one result word per request with
// the slot, a status code and the load flag for freshly claimed slots.
// Each slot lives in a cell of a row; a search token walks the row one cell
// per clock, then the update is applied to all cells at once.
// out_valid rises when the update is applied, and no new request is taken
// until the previous one has applied its update; in_stall holds it off.
// While a result waits under out_stall, the next request is still accepted
// and searched; its update waits until the output register is free.
// Reset (rst_n low, synchronous) empties every slot: keys, counts and free
// stamps read as zero, and both channels go idle.
// A stalled result word holds its value until taken.
module palette_slot_refcount_allocator #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_palette_key,
  input  logic [15:0] in_slot,
  input  logic [15:0] in_old_slot,
  input  logic [31:0] in_current_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot_out,
  output logic [1:0]  out_status,
  output logic        out_load_needed
);
  import psra_pkg::*;

  localparam logic [15:0] SLOTS_W16 = 16'(SLOTS);

  state_t      state_r, state_nxt;
  logic [2:0]  mode_r;
  logic [31:0] key_r;
  logic [15:0] slot_r;
  logic [15:0] old_r;
  logic [31:0] tick_r;
  tok_t        tok0_r;
  tok_t        res_r;
  tok_t        chain [0:SLOTS];

  logic        out_valid_r;
  logic [5:0]  out_slot_r;
  status_t     out_status_r;
  logic        out_load_r;

  scan_t       scan;
  upd_t        upd;
  logic        accept;
  logic        apply_go;
  logic [15:0] drop_sel;
  logic        drop_none, drop_bad;
  logic [IDX_W-1:0] res_slot;
  status_t     res_status;
  logic        res_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign apply_go = (state_r == ST_APPLY) && !(out_valid_r && out_stall);

  // Step the request sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (chain[SLOTS].valid) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Hold the command word for the whole request.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_palette_key;
      slot_r <= in_slot;
      old_r  <= in_old_slot;
      tick_r <= in_current_tick;
    end
  end

  // Launch a fresh token into the first cell on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r <= '{valid: accept, default: '0};
    end
  end

  // Capture the token as it leaves the last cell.
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && chain[SLOTS].valid) begin
      res_r <= chain[SLOTS];
    end
  end

  assign drop_sel       = (mode_r == MODE_COPY) ? old_r : slot_r;
  assign scan.key       = key_r;
  assign scan.tick      = tick_r;
  assign scan.drop_slot = drop_sel;

  assign chain[0] = tok0_r;

  // Row of slot cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    psra_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .scan  (scan),
      .upd   (upd),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign drop_none = (drop_sel == NO_SLOT);
  assign drop_bad  = !drop_none && ((drop_sel >= SLOTS_W16) || res_r.drop_zero);

  // Decide the table update and the result word from the search outcome.
  always_comb begin
    upd        = '0;
    upd.fire   = apply_go;
    upd.key    = key_r;
    upd.tick   = tick_r;
    upd.drop_idx = drop_sel[IDX_W-1:0];
    res_slot   = '0;
    res_status = STAT_OK;
    res_load   = 1'b0;
    case (mode_r)
      MODE_ACQUIRE: begin
        if (res_r.match_hit) begin
          upd.add_en  = 1'b1;
          upd.add_idx = res_r.match_idx;
          res_slot    = res_r.match_idx;
        end else if (res_r.free_hit) begin
          upd.add_en  = 1'b1;
          upd.add_idx = res_r.free_idx;
          upd.key_we  = 1'b1;
          res_slot    = res_r.free_idx;
          res_load    = 1'b1;
        end else begin
          res_status = STAT_NO_FREE;
        end
      end
      MODE_RELEASE: begin
        if (drop_bad) begin
          res_status = STAT_BAD_RELEASE;
        end else begin
          upd.drop_en = !drop_none;
        end
      end
      MODE_FIND: begin
        if (res_r.match_hit) begin
          res_slot = res_r.match_idx;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      MODE_COPY: begin
        if (drop_bad) begin
          res_status = STAT_BAD_RELEASE;
        end else begin
          upd.drop_en = !drop_none;
        end
        if (slot_r != NO_SLOT) begin
          if (slot_r < SLOTS_W16) begin
            upd.add_en  = 1'b1;
            upd.add_idx = slot_r[IDX_W-1:0];
            res_slot    = slot_r[IDX_W-1:0];
          end else begin
            res_status = STAT_BAD_RELEASE;
          end
        end
      end
      MODE_CLEAR: begin
        upd.clr = 1'b1;
      end
      default: begin
        upd.fire = apply_go;
      end
    endcase
  end

  // Load the output register on update, drop it when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_slot_r   <= res_slot[5:0];
      out_status_r <= res_status;
      out_load_r   <= res_load;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = out_slot_r;
  assign out_status      = out_status_r;
  assign out_load_needed = out_load_r;

endmodule

### hdl/psra_checker.sv
// Port-level checker for the palette slot allocator, bound to the top level.
`include "palette_slot_refcount_allocator_assert.svh"

module psra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_slot_out,
  input logic [1:0]  out_status,
  input logic        out_load_needed
);
  import psra_pkg::*;

  // A stalled result word stays offered.
  `PSRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A claimed slot always comes with an ok status.
  `PSRA_ASSERT_NOW(a_load_ok, clk, rst_n, out_valid && out_load_needed, out_status == STAT_OK)

  // A full table reports slot zero and no load.
  `PSRA_ASSERT_NOW(a_nofree_clean, clk, rst_n,
                   out_valid && (out_status == STAT_NO_FREE),
                   (out_slot_out == 6'd0) && !out_load_needed)

  // Reset leaves no result on the output.
  `PSRA_ASSERT_ALWAYS_NEXT(a_rst_idle, clk, !rst_n, !out_valid)

endmodule

bind palette_slot_refcount_allocator psra_checker u_psra_checker (.*);

### tb/palette_slot_refcount_allocator_tb.sv
// Testbench for the palette slot allocator: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module palette_slot_refcount_allocator_tb;
  import psra_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam int LATENCY     = TABLE_SLOTS + 3;
  localparam int RANDOM_REQS = 950;
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  typedef struct packed {
    logic [5:0] slot_out;
    status_t    status;
    logic       load_needed;
  } slot_reply_t;

  // Mirror of the slot table that predicts each reply word in accept order.
  class slot_table_scoreboard #(int N = 64);
    logic [31:0] key_tab[N];
    logic [15:0] refs_tab[N];
    logic [31:0] stamp_tab[N];
    slot_reply_t replies_due[$];
    int errors = 0;
    int checked = 0;
    int requests = 0;
    int claims = 0;
    int no_free = 0;
    int not_found = 0;
    int bad_release = 0;
    int clears = 0;

    function void reset_table();
      for (int i = 0; i < N; i++) begin
        key_tab[i]   = '0;
        refs_tab[i]  = '0;
        stamp_tab[i] = '0;
      end
    endfunction

    function int lookup(logic [31:0] key);
      for (int i = 0; i < N; i++)
        if (key_tab[i] == key) return i;
      return -1;
    endfunction

    // Saturate the count at its maximum.
    function void add_ref(int idx);
      if (refs_tab[idx] != REFS_MAX) refs_tab[idx] = refs_tab[idx] + 16'd1;
    endfunction

    // Drop one reference; return 1 when the release is illegal.
    function bit drop_ref(logic [15:0] s, logic [31:0] tick);
      if (s == NO_SLOT) return 1'b0;
      if (s >= N || refs_tab[s] == 16'd0) return 1'b1;
      if (refs_tab[s] == 16'd1) stamp_tab[s] = tick;
      refs_tab[s] = refs_tab[s] - 16'd1;
      return 1'b0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(mode_t m, logic [31:0] key, logic [15:0] s,
                               logic [15:0] old_s, logic [31:0] tick);
      slot_reply_t r;
      int hit;
      r = '{slot_out: 6'd0, status: STAT_OK, load_needed: 1'b0};
      requests++;
      case (m)
        MODE_ACQUIRE: begin
          hit = lookup(key);
          if (hit >= 0) begin
            add_ref(hit);
            r.slot_out = 6'(hit);
          end else begin
            // claim the lowest idle slot not freed in this tick
            r.status = STAT_NO_FREE;
            for (int i = 0; i < N; i++) begin
              if (refs_tab[i] == 16'd0 && (stamp_tab[i] == 32'd0 || stamp_tab[i] != tick)) begin
                add_ref(i);
                key_tab[i] = key;
                r.slot_out = 6'(i);
                r.status = STAT_OK;
                r.load_needed = 1'b1;
                break;
              end
            end
          end
        end
        MODE_RELEASE: begin
          if (drop_ref(s, tick)) r.status = STAT_BAD_RELEASE;
        end
        MODE_FIND: begin
          hit = lookup(key);
          if (hit >= 0) r.slot_out = 6'(hit);
          else r.status = STAT_NOT_FOUND;
        end
        MODE_COPY: begin
          if (drop_ref(old_s, tick)) r.status = STAT_BAD_RELEASE;
          if (s != NO_SLOT) begin
            if (s < N) begin
              add_ref(int'(s));
              r.slot_out = s[5:0];
            end else begin
              r.status = STAT_BAD_RELEASE;
            end
          end
        end
        MODE_CLEAR: begin
          reset_table();
          clears++;
        end
        default: ;
      endcase
      if (r.load_needed) claims++;
      if (r.status == STAT_NO_FREE) no_free++;
      if (r.status == STAT_NOT_FOUND) not_found++;
      if (r.status == STAT_BAD_RELEASE) bad_release++;
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [5:0] slot_out, logic [1:0] status, logic load);
      slot_reply_t want;
      checked++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply word with nothing expected (slot %0d status %0d load %0d)",
                 $time, slot_out, status, load);
        return;
      end
      want = replies_due.pop_front();
      if (slot_out !== want.slot_out) begin
        errors++;
        $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out, slot_out);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (load !== want.load_needed) begin
        errors++;
        $display("%0t: load_needed expected %0d actual %0d", $time, want.load_needed, load);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [31:0] in_palette_key;
  logic [15:0] in_slot;
  logic [15:0] in_old_slot;
  logic [31:0] in_current_tick;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_slot_out;
  logic [1:0]  out_status;
  logic        out_load_needed;

  slot_table_scoreboard #(TABLE_SLOTS) sb;
  logic [31:0] key_pool[16];
  int burst_left = 0;

  palette_slot_refcount_allocator #(.SLOTS(TABLE_SLOTS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_palette_key  (in_palette_key),
    .in_slot         (in_slot),
    .in_old_slot     (in_old_slot),
    .in_current_tick (in_current_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_out    (out_slot_out),
    .out_status      (out_status),
    .out_load_needed (out_load_needed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Mostly in-range slots, with none and out-of-range values mixed in.
  function automatic logic [15:0] pick_slot();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(15));
    if (r < 80) return 16'($urandom_range(TABLE_SLOTS - 1, 16));
    if (r < 88) return NO_SLOT;
    return 16'($urandom_range(16'hffff));
  endfunction

  // Reuse pooled keys so acquires and finds hit the table often.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 65) return key_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  // Offer one request word and hold it until accepted.
  task automatic issue(mode_t m, logic [31:0] key, logic [15:0] s,
                       logic [15:0] old_s, logic [31:0] tick);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(90, 1)) @(posedge clk);
      burst_left = $urandom_range(10);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_palette_key  <= key;
    in_slot         <= s;
    in_old_slot     <= old_s;
    in_current_tick <= tick;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(m, key, s, old_s, tick);
  endtask

  // Take reply words under a changing stall pattern, with one long hold-off.
  initial begin : result_sink
    int phase_left;
    int stall_pct;
    int hold_left;
    bit long_hold_done;
    int pct_choices[5];
    pct_choices = '{0, 0, 30, 70, 95};
    phase_left = 0;
    stall_pct = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall)
        sb.check_result(out_slot_out, out_status, out_load_needed);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && sb.checked >= 150) begin
        hold_left = 600;
        long_hold_done = 1'b1;
      end else if (phase_left == 0) begin
        phase_left = $urandom_range(400, 20);
        stall_pct = pct_choices[$urandom_range(4)];
      end else begin
        phase_left--;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    int random_sent;
    int fills_done;
    int k;
    int r;
    mode_t m;
    logic [31:0] cur_tick;
    logic [31:0] fill_tick;

    sb = new();
    sb.reset_table();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_palette_key = '0;
    in_slot = '0;
    in_old_slot = '0;
    in_current_tick = '0;
    for (k = 0; k < 16; k++) key_pool[k] = (k == 0) ? 32'd0 : $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: key zero, fresh claims, same-tick reuse block, bad releases, copies, clear.
    issue(MODE_ACQUIRE, 32'h0000_0000, 16'd0, 16'd0, 32'd1);
    issue(MODE_ACQUIRE, 32'hffff_ffff, 16'hffff, 16'hffff, 32'd1);
    issue(MODE_ACQUIRE, 32'ha5a5_a5a5, 16'd0, 16'd0, 32'd1);
    issue(MODE_FIND, 32'hffff_ffff, 16'd0, 16'd0, 32'd1);
    issue(MODE_FIND, 32'h5a5a_5a5a, 16'd0, 16'd0, 32'd1);
    issue(MODE_RELEASE, 32'd0, 16'd1, 16'd0, 32'd7);
    issue(MODE_ACQUIRE, 32'h5a5a_5a5a, 16'd0, 16'd0, 32'd7);
    issue(MODE_ACQUIRE, 32'hffff_ffff, 16'd0, 16'd0, 32'd7);
    issue(MODE_RELEASE, 32'd0, NO_SLOT, 16'd0, 32'd7);
    issue(MODE_RELEASE, 32'd0, 16'd64, 16'd0, 32'd7);
    issue(MODE_RELEASE, 32'd0, 16'hfffe, 16'd0, 32'd7);
    issue(MODE_RELEASE, 32'd0, 16'd40, 16'd0, 32'd7);
    issue(MODE_COPY, 32'd0, 16'd2, 16'd1, 32'd9);
    issue(MODE_COPY, 32'd0, NO_SLOT, NO_SLOT, 32'd9);
    issue(MODE_COPY, 32'd0, 16'd5, 16'd70, 32'd9);
    issue(MODE_COPY, 32'd0, 16'd100, 16'd1, 32'd9);
    issue(MODE_RELEASE, 32'd0, 16'd3, 16'd0, 32'd0);
    issue(MODE_ACQUIRE, 32'h0bad_f00d, 16'd0, 16'd0, 32'd0);
    issue(MODE_ACQUIRE, 32'h0000_0001, 16'd0, 16'd0, 32'd0);
    issue(MODE_FIND, 32'h0000_0000, 16'd0, 16'd0, 32'd0);
    issue(MODE_CLEAR, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    issue(MODE_FIND, 32'hffff_ffff, 16'd0, 16'd0, 32'd0);
    issue(MODE_ACQUIRE, 32'hffff_ffff, 16'd0, 16'd0, 32'hffff_ffff);
    issue(MODE_RELEASE, 32'd0, 16'd0, 16'd0, 32'hffff_ffff);
    issue(MODE_ACQUIRE, 32'h1234_5678, 16'd0, 16'd0, 32'hffff_ffff);

    // Random traffic with periodic table fills to reach the no-free case.
    random_sent = 0;
    fills_done = 0;
    cur_tick = 32'd100;
    while (random_sent < RANDOM_REQS) begin
      if (fills_done < 3 && random_sent >= 150 + 300 * fills_done) begin
        fill_tick = $urandom | 32'h1;
        for (k = 0; k < 66; k++)
          issue(MODE_ACQUIRE, $urandom, pick_slot(), pick_slot(), fill_tick);
        for (k = 0; k < 3; k++)
          issue(MODE_RELEASE, pick_key(), 16'($urandom_range(TABLE_SLOTS - 1)),
                pick_slot(), fill_tick);
        for (k = 0; k < 3; k++)
          issue(MODE_ACQUIRE, $urandom, pick_slot(), pick_slot(), fill_tick);
        cur_tick = fill_tick + 32'd1;
        issue(MODE_ACQUIRE, $urandom, pick_slot(), pick_slot(), cur_tick);
        random_sent += 73;
        fills_done++;
        continue;
      end

      // advance the frame tick now and then
      r = $urandom_range(99);
      if (r < 20) cur_tick = cur_tick + 32'd1;
      else if (r < 24) cur_tick = $urandom;
      else if (r < 27) cur_tick = 32'd0;
      if ($urandom_range(99) < 2) key_pool[$urandom_range(15, 1)] = $urandom;

      if ($urandom_range(99) < 5) begin
        // noise word: every field uniform
        issue(mode_t'($urandom_range(4)), $urandom, 16'($urandom_range(16'hffff)),
              16'($urandom_range(16'hffff)), $urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 3) m = MODE_CLEAR;
        else if (r < 40) m = MODE_ACQUIRE;
        else if (r < 65) m = MODE_RELEASE;
        else if (r < 80) m = MODE_FIND;
        else m = MODE_COPY;
        issue(m, pick_key(), pick_slot(), pick_slot(), cur_tick);
      end
      random_sent++;
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray reply words.
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d requests: %0d fresh claims, %0d no-free, %0d not-found,",
             sb.requests, sb.claims, sb.no_free, sb.not_found);
    $display("%0d bad releases, %0d clears; checked %0d reply words, %0d field mismatches",
             sb.bad_release, sb.clears, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
